[design/rfcc_pkg.sv]
// rfcc_pkg: shared types, constants and the crc byte update for the
// response frame crc checker; no dependencies
package rfcc_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 2);
    localparam int FIFO_DEPTH      = 4;
    localparam int PTR_W           = $clog2(FIFO_DEPTH);
    localparam int FILL_W          = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_W-1:0] MIN_FRAME      = CNT_W'(6);
    localparam logic [CNT_W-1:0] FRAME_OVERHEAD = CNT_W'(5);
    localparam logic [CNT_W-1:0] PAYLOAD_FIRST  = CNT_W'(5);
    localparam logic [CNT_W-1:0] CRC_FIRST      = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_LIMIT      = CNT_W'(MAX_FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_OVERRUN    = CNT_W'(MAX_FRAME_BYTES + 1);

    localparam logic [15:0] CRC_POLY_RESET = 16'h8408;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] ST_ACCEPTED  = 2'd0;
    localparam logic [1:0] ST_TOO_SHORT = 2'd1;
    localparam logic [1:0] ST_CRC_BAD   = 2'd2;
    localparam logic [1:0] ST_OVERRUN   = 2'd3;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic [1:0] status_code;
        logic [7:0] payload_length;
        logic       last;
    } t_result;

    function automatic logic [15:0] crc_feed(
        input logic [15:0] crc,
        input logic [7:0]  data,
        input logic [15:0] poly
    );
        logic [15:0] c;
        c = crc ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ poly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[design/rfcc_in_if.sv]
// rfcc_in_if: input byte channel with valid/ready handshake
// no dependencies
interface rfcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_frame;

    modport source (output valid, output rx_byte, output end_of_frame, input ready);
    modport sink   (input valid, input rx_byte, input end_of_frame, output ready);
endinterface

[design/rfcc_out_if.sv]
// rfcc_out_if: result channel with valid/ready handshake
// no dependencies
interface rfcc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       kind;
    logic [1:0] status_code;
    logic [7:0] payload_length;
    logic       last;

    modport source (output valid, output out_byte, output kind, output status_code,
                    output payload_length, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input status_code,
                    input payload_length, input last, output ready);
endinterface

[design/response_frame_crc_checker_unit.sv]
// response_frame_crc_checker_unit: byte-wise response frame check with crc-16
// depends on rfcc_pkg, rfcc_in_if, rfcc_out_if
//
// usage
//   i_rx carries one frame byte per transaction, end_of_frame set on the last
//   byte. o_res carries payload bytes (kind 0) as they leave the two-byte tail
//   delay, and one status transaction (kind 1, last 1) at the end of a frame.
//   i_cfg_wr_en/i_cfg_wr_data set the reflected crc polynomial; write only
//   while the block is idle.
// timing
//   one byte accepted per cycle while i_rx.ready is high. frame state and crc
//   are updated in the accept cycle and the results enter a four-entry result
//   queue, so a result is offered in the cycle after its byte. an end byte
//   that also frees a payload byte yields two results, drained one per cycle
//   while o_res.ready is high. i_rx.ready is high while the queue has room for
//   two results, so a stalled receiver holds off the sender once it fills.
// reset
//   synchronous active-low reset empties the queue, clears the frame state
//   and loads the polynomial 0x8408.
module response_frame_crc_checker_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rfcc_in_if.sink            i_rx,
    rfcc_out_if.source         o_res,
    input  logic               i_cfg_wr_en,
    input  logic [15:0]        i_cfg_wr_data
);

    logic [15:0]                 r_poly;
    logic [rfcc_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [15:0]                 r_crc, n_crc;
    logic [7:0]                  r_tail0, n_tail0;
    logic [7:0]                  r_tail1, n_tail1;

    rfcc_pkg::t_result           r_fifo [rfcc_pkg::FIFO_DEPTH];
    logic [rfcc_pkg::PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [rfcc_pkg::FILL_W-1:0] r_fill, n_fill;

    logic                        acc, pop;
    logic                        emit_pay, emit_stat;
    rfcc_pkg::t_result           pay_res, stat_res;
    logic [1:0]                  n_push;
    logic [rfcc_pkg::CNT_W-1:0]  plen_full;

    assign acc = i_rx.valid && i_rx.ready;
    assign pop = o_res.valid && o_res.ready;

    assign i_rx.ready = (r_fill <= rfcc_pkg::FILL_W'(rfcc_pkg::FIFO_DEPTH - 2));

    // frame state update for one byte
    always_comb begin
        n_crc     = r_crc;
        n_tail0   = r_tail0;
        n_tail1   = r_tail1;
        emit_pay  = 1'b0;
        emit_stat = i_rx.end_of_frame;
        if (r_cnt < rfcc_pkg::CNT_LIMIT) begin
            if (r_cnt >= rfcc_pkg::CRC_FIRST) begin
                n_crc = rfcc_pkg::crc_feed(r_crc, r_tail0, r_poly);
            end
            emit_pay = (r_cnt >= rfcc_pkg::PAYLOAD_FIRST);
            n_tail0  = r_tail1;
            n_tail1  = i_rx.rx_byte;
            n_cnt    = r_cnt + rfcc_pkg::CNT_W'(1);
        end else begin
            n_cnt = rfcc_pkg::CNT_OVERRUN;
        end
    end

    always_comb begin
        pay_res                = '0;
        pay_res.out_byte       = r_tail0;
        pay_res.kind           = rfcc_pkg::KIND_PAYLOAD;

        plen_full              = n_cnt - rfcc_pkg::FRAME_OVERHEAD;
        stat_res               = '0;
        stat_res.kind          = rfcc_pkg::KIND_STATUS;
        stat_res.last          = 1'b1;
        if (n_cnt > rfcc_pkg::CNT_LIMIT) begin
            stat_res.status_code = rfcc_pkg::ST_OVERRUN;
        end else if (n_cnt < rfcc_pkg::MIN_FRAME) begin
            stat_res.status_code = rfcc_pkg::ST_TOO_SHORT;
        end else begin
            stat_res.payload_length = plen_full[7:0];
            if (n_crc[7:0] == n_tail0 && n_crc[15:8] == n_tail1) begin
                stat_res.status_code = rfcc_pkg::ST_ACCEPTED;
            end else begin
                stat_res.status_code = rfcc_pkg::ST_CRC_BAD;
            end
        end
    end

    always_comb begin
        n_push = 2'd0;
        if (acc) begin
            n_push = {1'b0, emit_pay} + {1'b0, emit_stat};
        end
        n_fill = r_fill + rfcc_pkg::FILL_W'(n_push) - rfcc_pkg::FILL_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly   <= rfcc_pkg::CRC_POLY_RESET;
            r_cnt    <= '0;
            r_crc    <= '0;
            r_tail0  <= '0;
            r_tail1  <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_poly <= i_cfg_wr_data;
            end
            if (acc) begin
                if (i_rx.end_of_frame) begin
                    r_cnt   <= '0;
                    r_crc   <= '0;
                    r_tail0 <= '0;
                    r_tail1 <= '0;
                end else begin
                    r_cnt   <= n_cnt;
                    r_crc   <= n_crc;
                    r_tail0 <= n_tail0;
                    r_tail1 <= n_tail1;
                end
            end
            r_wr_ptr <= r_wr_ptr + rfcc_pkg::PTR_W'(n_push);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + rfcc_pkg::PTR_W'(1);
            end
            r_fill <= n_fill;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (acc) begin
            if (emit_pay) begin
                r_fifo[r_wr_ptr] <= pay_res;
                if (emit_stat) begin
                    r_fifo[r_wr_ptr + rfcc_pkg::PTR_W'(1)] <= stat_res;
                end
            end else if (emit_stat) begin
                r_fifo[r_wr_ptr] <= stat_res;
            end
        end
    end

    assign o_res.valid          = (r_fill != '0);
    assign o_res.out_byte       = r_fifo[r_rd_ptr].out_byte;
    assign o_res.kind           = r_fifo[r_rd_ptr].kind;
    assign o_res.status_code    = r_fifo[r_rd_ptr].status_code;
    assign o_res.payload_length = r_fifo[r_rd_ptr].payload_length;
    assign o_res.last           = r_fifo[r_rd_ptr].last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= rfcc_pkg::FILL_W'(rfcc_pkg::FIFO_DEPTH))
        else $error("result queue overfilled");

    a_eof_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && i_rx.end_of_frame |=> r_cnt == '0 && r_crc == '0)
        else $error("frame state not cleared after end of frame");

    a_fill_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc && !pop |=> $stable(r_fill))
        else $error("queue fill changed without a transaction");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill[rfcc_pkg::PTR_W-1:0] == r_wr_ptr - r_rd_ptr)
        else $error("queue pointers disagree with fill");

endmodule
